@@ design/eaus_pkg.sv @@
// Shared types, constants and codes for the encoder unwrap and speed block.
package eaus_pkg;

    localparam int ANGLE_W    = 12;
    localparam int DEG_W      = 21;
    localparam int SPEED_W    = 24;
    localparam int POS_W      = 32;
    localparam int TIME_W     = 32;
    localparam int WINDOW_W   = 24;
    localparam int DEADZONE_W = 16;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int SCALE_W    = 22;
    localparam int PROD_W     = POS_W + SCALE_W;
    localparam int QUO_W      = SPEED_W;
    localparam int STEP_W     = ANGLE_W + 2;

    localparam logic [CFG_IDX_W-1:0]  CFG_WINDOW_US  = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_DEADZONE   = 1'b1;

    localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 24'd200000;
    localparam logic [DEADZONE_W-1:0] DEADZONE_RESET = 16'd102;

    // counts * RPM_SCALE / elapsed_us is rpm in Q8
    localparam logic [SCALE_W-1:0]    RPM_SCALE      = 22'd3750000;
    localparam logic [DEG_W-1:0]      DEG_PER_TURN   = 21'd360;

    localparam logic signed [STEP_W-1:0] HALF_TURN = 14'sd2048;
    localparam logic signed [STEP_W-1:0] FULL_TURN = 14'sd4096;

    localparam logic [SPEED_W-1:0] SPEED_MAX_POS = 24'h7FFFFF;
    localparam logic [SPEED_W-1:0] SPEED_MAX_NEG = 24'h800000;

    typedef struct packed {
        logic [7:0]        status_byte;
        logic [7:0]        angle_high;
        logic [7:0]        angle_low;
        logic [TIME_W-1:0] time_us;
    } t_in_word;

    typedef struct packed {
        logic [ANGLE_W-1:0]        raw_angle;
        logic [DEG_W-1:0]          angle_deg_q12;
        logic signed [SPEED_W-1:0] speed_rpm_q8;
        logic                      magnet_detected;
        logic                      mag_field_low;
        logic                      mag_field_high;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNWRAP,
        ST_ABS,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SAT,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
    } t_div_sts;

endpackage

@@ design/encoder_angle_unwrap_speed_core.sv @@
// Top level: angle unwrap, windowed speed sequencer and output register.
// Each accepted word passes through the unwrap state, then, when a speed update is due, the abs,
// multiply, divide start, divide wait and saturate states, and last the finish state that loads
// the output register; the divide is skipped when the quotient overflows 24 bits.
// The input is not ready until the previous result sits in the output register.
// Synchronous active-low reset clears tracking state and restores both config registers.
module encoder_angle_unwrap_speed_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [eaus_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [eaus_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  eaus_pkg::t_in_word               i_in_word,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output eaus_pkg::t_out_word              o_out_word
);
    import eaus_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [WINDOW_W-1:0]   r_window;
    logic [DEADZONE_W-1:0] r_deadzone;

    logic                  r_seen_first;
    logic [ANGLE_W-1:0]    r_last_angle;
    logic [POS_W-1:0]      r_position;
    logic [POS_W-1:0]      r_ref_position;
    logic [TIME_W-1:0]     r_ref_time;
    logic [SPEED_W-1:0]    r_held;

    logic [ANGLE_W-1:0]    r_angle;
    logic [7:0]            r_status;
    logic [TIME_W-1:0]     r_now;
    logic [POS_W-1:0]      r_counts;
    logic                  r_neg;
    logic [POS_W-1:0]      r_mag;
    logic [PROD_W-1:0]     r_prod;
    logic [TIME_W-1:0]     r_elapsed;

    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic                  w_accept;
    logic                  w_out_free;
    logic signed [STEP_W-1:0] w_step_raw;
    logic signed [STEP_W-1:0] w_step;
    logic [POS_W-1:0]      w_pos_next;
    logic [TIME_W-1:0]     w_elapsed;
    logic [TIME_W-1:0]     w_win;
    logic                  w_update;
    logic [QUO_W-1:0]      w_quotient;
    logic [QUO_W-1:0]      w_q;
    logic [SPEED_W-1:0]    w_speed;

    t_div_ctl              w_div_ctl;
    t_div_sts              w_div_sts;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // fold the step into plus or minus half a turn; exactly half a turn stays
    always_comb begin
        w_step_raw = signed'(STEP_W'(r_angle)) - signed'(STEP_W'(r_last_angle));
        if (w_step_raw > HALF_TURN) begin
            w_step = w_step_raw - FULL_TURN;
        end else if (w_step_raw < -HALF_TURN) begin
            w_step = w_step_raw + FULL_TURN;
        end else begin
            w_step = w_step_raw;
        end
    end

    assign w_pos_next = r_position + POS_W'(w_step);
    assign w_elapsed  = r_now - r_ref_time;
    assign w_win      = (r_window == '0) ? TIME_W'(1) : TIME_W'(r_window);
    assign w_update   = (w_elapsed >= w_win);

    // deadzone, then saturate and restore the sign
    assign w_q = w_div_sts.ovf ? {QUO_W{1'b1}} : w_quotient;

    always_comb begin
        if (!w_div_sts.ovf && (w_q <= QUO_W'(r_deadzone))) begin
            w_speed = '0;
        end else if (r_neg) begin
            w_speed = (w_q >= SPEED_MAX_NEG) ? SPEED_MAX_NEG : (~w_q + 1'b1);
        end else begin
            w_speed = (w_q > SPEED_MAX_POS) ? SPEED_MAX_POS : w_q;
        end
    end

    eaus_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (r_prod),
        .i_divisor  (r_elapsed),
        .o_sts      (w_div_sts),
        .o_quotient (w_quotient)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_UNWRAP;
            end
            ST_UNWRAP: begin
                n_state = (r_seen_first && w_update) ? ST_ABS : ST_FIN;
            end
            ST_ABS:       n_state = ST_MUL;
            ST_MUL:       n_state = ST_DIV_START;
            ST_DIV_START: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (w_div_sts.done) n_state = ST_SAT;
            end
            ST_SAT:       n_state = ST_FIN;
            ST_FIN: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready      = 1'b0;
        w_div_ctl.start = 1'b0;
        case (r_state)
            ST_IDLE:      o_in_ready      = 1'b1;
            ST_DIV_START: w_div_ctl.start = 1'b1;
            default: begin
                o_in_ready      = 1'b0;
                w_div_ctl.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window   <= WINDOW_RESET;
            r_deadzone <= DEADZONE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_US: r_window   <= i_cfg_data[WINDOW_W-1:0];
                CFG_DEADZONE:  r_deadzone <= i_cfg_data[DEADZONE_W-1:0];
                default: begin
                    r_window   <= r_window;
                    r_deadzone <= r_deadzone;
                end
            endcase
        end
    end

    // tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_first   <= 1'b0;
            r_last_angle   <= '0;
            r_position     <= '0;
            r_ref_position <= '0;
            r_ref_time     <= '0;
            r_held         <= '0;
        end else if (r_state == ST_UNWRAP) begin
            r_seen_first <= 1'b1;
            r_last_angle <= r_angle;
            if (!r_seen_first) begin
                // seed position, speed reference and window start
                r_position     <= POS_W'(r_angle);
                r_ref_position <= POS_W'(r_angle);
                r_ref_time     <= r_now;
                r_held         <= '0;
            end else begin
                r_position <= w_pos_next;
                if (w_update) begin
                    r_ref_position <= w_pos_next;
                    r_ref_time     <= r_now;
                end
            end
        end else if (r_state == ST_SAT) begin
            r_held <= w_speed;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_angle  <= {i_in_word.angle_high[3:0], i_in_word.angle_low};
            r_status <= i_in_word.status_byte;
            r_now    <= i_in_word.time_us;
        end
        if (r_state == ST_UNWRAP) begin
            r_counts  <= w_pos_next - r_ref_position;
            r_elapsed <= w_elapsed;
        end
        if (r_state == ST_ABS) begin
            r_neg <= r_counts[POS_W-1];
            r_mag <= r_counts[POS_W-1] ? (~r_counts + 1'b1) : r_counts;
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(RPM_SCALE);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FIN && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN && w_out_free) begin
            r_out_word.raw_angle       <= r_angle;
            r_out_word.angle_deg_q12   <= DEG_W'(r_angle) * DEG_PER_TURN;
            r_out_word.speed_rpm_q8    <= signed'(r_held);
            r_out_word.magnet_detected <= r_status[5];
            r_out_word.mag_field_low   <= r_status[4];
            r_out_word.mag_field_high  <= r_status[3];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ design/eaus_divider.sv @@
// Shift-subtract divider: one quotient bit per cycle, flags quotients that overflow 24 bits.
module eaus_divider (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  eaus_pkg::t_div_ctl           i_ctl,
    input  logic [eaus_pkg::PROD_W-1:0]  i_dividend,
    input  logic [eaus_pkg::TIME_W-1:0]  i_divisor,
    output eaus_pkg::t_div_sts           o_sts,
    output logic [eaus_pkg::QUO_W-1:0]   o_quotient
);
    import eaus_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [TIME_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_lo;
    logic [TIME_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              r_ovf;

    logic [TIME_W-1:0] w_top;
    logic              w_top_ovf;
    logic [TIME_W:0]   w_shift;
    logic [TIME_W:0]   w_diff;
    logic              w_qbit;

    // quotient reaches 2^24 exactly when the upper dividend bits reach the divisor
    assign w_top     = TIME_W'(i_dividend[PROD_W-1:QUO_W]);
    assign w_top_ovf = (w_top >= i_divisor);

    assign w_shift = {r_rem, r_lo[QUO_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_qbit  = !w_diff[TIME_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= !w_top_ovf;
                r_done <= w_top_ovf;
                r_cnt  <= CNT_W'(QUO_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= w_top;
            r_lo  <= i_dividend[QUO_W-1:0];
            r_div <= i_divisor;
            r_ovf <= w_top_ovf;
        end else if (r_busy) begin
            // shift the next dividend bit in, keep the difference when it fits
            r_rem <= w_qbit ? w_diff[TIME_W-1:0] : w_shift[TIME_W-1:0];
            r_lo  <= {r_lo[QUO_W-2:0], w_qbit};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_sts.ovf  = r_ovf;
    assign o_quotient = r_lo;

endmodule

@@ design/eaus_checker.sv @@
// Port-level checks for the encoder unwrap and speed block, bound to the top level.
module eaus_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input eaus_pkg::t_out_word o_out_word
);
    import eaus_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // one word in flight: drop ready after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while a word is in progress");

    // a result never appears in the cycle right after an accept
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(i_in_valid && o_in_ready))
        else $error("result appeared too early");

    // degrees field follows the raw angle
    a_deg_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.angle_deg_q12 ==
            DEG_W'(o_out_word.raw_angle) * DEG_PER_TURN)
        else $error("degree field does not match raw angle");

endmodule

bind encoder_angle_unwrap_speed_core eaus_checker u_eaus_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the encoder unwrap and speed core: directed table, then random phases.
module testbench;
    import eaus_pkg::*;

    typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;

    // For sample rows, sample.time_us holds the step from the previous stamp.
    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        t_in_word               sample;
        bit                     typed;
        t_out_word              want;
    } stim_row_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_idx  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    t_in_word               in_word  = '0;
    logic                   out_ready = 1'b0;
    logic                   in_ready;
    logic                   out_valid;
    t_out_word              out_word;

    stim_row_t   stim_rows[$];
    t_out_word   pending_words[$];
    int          fail_count  = 0;
    int          stall_left  = 0;
    int          stall_mode  = 0;
    logic [31:0] drive_stamp = 32'hFFFF_FFF0;

    // Predictor copy of the block's registers and state
    logic [WINDOW_W-1:0]   window_reg   = WINDOW_RESET;
    logic [DEADZONE_W-1:0] deadzone_reg = DEADZONE_RESET;
    bit                    have_first   = 1'b0;
    logic [ANGLE_W-1:0]    last_raw     = '0;
    logic [POS_W-1:0]      pos_count    = '0;
    logic [POS_W-1:0]      ref_pos      = '0;
    logic [TIME_W-1:0]     ref_stamp    = '0;
    logic [SPEED_W-1:0]    held_rpm     = '0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    encoder_angle_unwrap_speed_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // counts * scale / elapsed, truncated toward zero, deadzoned, saturated
    function automatic logic [SPEED_W-1:0] rpm_q8_from(logic [31:0] counts, logic [31:0] elapsed);
        longint unsigned mag;
        longint unsigned q;
        logic            neg;
        neg = counts[31];
        mag = {32'd0, (neg ? (~counts + 32'd1) : counts)};
        q   = (mag * {42'd0, RPM_SCALE}) / {32'd0, elapsed};
        if (q <= {48'd0, deadzone_reg}) begin
            return '0;
        end
        if (neg) begin
            if (q > {40'd0, SPEED_MAX_NEG}) q = {40'd0, SPEED_MAX_NEG};
            return ~q[SPEED_W-1:0] + 24'd1;
        end
        if (q > {40'd0, SPEED_MAX_POS}) q = {40'd0, SPEED_MAX_POS};
        return q[SPEED_W-1:0];
    endfunction

    function automatic t_out_word predict_sample(t_in_word w);
        logic [ANGLE_W-1:0]       ang;
        logic signed [STEP_W-1:0] step;
        logic [31:0]              win;
        logic [31:0]              elapsed;
        t_out_word                r;
        ang = {w.angle_high[3:0], w.angle_low};
        if (!have_first) begin
            pos_count = {20'd0, ang};
            ref_pos   = {20'd0, ang};
            ref_stamp = w.time_us;
            held_rpm  = '0;
        end else begin
            step = $signed({2'b00, ang}) - $signed({2'b00, last_raw});
            // fold into half a turn either way; exactly half a turn stays as it is
            if (step > HALF_TURN) step = step - FULL_TURN;
            else if (step < -HALF_TURN) step = step + FULL_TURN;
            pos_count = pos_count + {{18{step[STEP_W-1]}}, step};
            win       = (window_reg == '0) ? 32'd1 : {8'd0, window_reg};
            elapsed   = w.time_us - ref_stamp;
            if (elapsed >= win) begin
                held_rpm  = rpm_q8_from(pos_count - ref_pos, elapsed);
                ref_pos   = pos_count;
                ref_stamp = w.time_us;
            end
        end
        last_raw   = ang;
        have_first = 1'b1;
        r.raw_angle       = ang;
        r.angle_deg_q12   = {9'd0, ang} * DEG_PER_TURN;
        r.speed_rpm_q8    = held_rpm;
        r.magnet_detected = w.status_byte[5];
        r.mag_field_low   = w.status_byte[4];
        r.mag_field_high  = w.status_byte[3];
        return r;
    endfunction

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        stim_row_t row;
        row          = '{kind: ROW_CFG, default: '0};
        row.reg_idx  = idx;
        row.reg_data = data;
        stim_rows.push_back(row);
    endtask

    task automatic add_sample(logic [7:0] st, logic [7:0] ah, logic [7:0] al, logic [31:0] delta,
                              bit typed, t_out_word want);
        stim_row_t row;
        row        = '{kind: ROW_SAMPLE, default: '0};
        row.sample = '{status_byte: st, angle_high: ah, angle_low: al, time_us: delta};
        row.typed  = typed;
        row.want   = want;
        stim_rows.push_back(row);
    endtask

    // Drop valid and hold until every pending word has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WINDOW_US) window_reg = data[WINDOW_W-1:0];
        else if (idx == CFG_DEADZONE) deadzone_reg = data[DEADZONE_W-1:0];
    endtask

    task automatic idle_sender(int unsigned gap);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic send_sample(t_in_word w, bit typed, t_out_word want);
        t_out_word guess;
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        forever begin
            @(posedge clk);
            if (in_ready) break;
        end
        guess = predict_sample(w);
        pending_words.push_back(typed ? want : guess);
    endtask

    task automatic check_word(t_out_word exp_w, t_out_word got);
        if (got.raw_angle !== exp_w.raw_angle) begin
            $error("raw_angle expected %0d got %0d", exp_w.raw_angle, got.raw_angle);
            fail_count++;
        end
        if (got.angle_deg_q12 !== exp_w.angle_deg_q12) begin
            $error("angle_deg_q12 expected %0d got %0d", exp_w.angle_deg_q12, got.angle_deg_q12);
            fail_count++;
        end
        if (got.speed_rpm_q8 !== exp_w.speed_rpm_q8) begin
            $error("speed_rpm_q8 expected %0d got %0d", exp_w.speed_rpm_q8, got.speed_rpm_q8);
            fail_count++;
        end
        if (got.magnet_detected !== exp_w.magnet_detected) begin
            $error("magnet_detected expected %0b got %0b",
                   exp_w.magnet_detected, got.magnet_detected);
            fail_count++;
        end
        if (got.mag_field_low !== exp_w.mag_field_low) begin
            $error("mag_field_low expected %0b got %0b", exp_w.mag_field_low, got.mag_field_low);
            fail_count++;
        end
        if (got.mag_field_high !== exp_w.mag_field_high) begin
            $error("mag_field_high expected %0b got %0b",
                   exp_w.mag_field_high, got.mag_field_high);
            fail_count++;
        end
    endtask

    // Receiver: alternate stretches of always ready, coin-flip, and mostly stalled
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(8, 150);
        end
        stall_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_words.size() == 0) begin
                $error("result word arrived with nothing pending");
                fail_count++;
            end else begin
                check_word(pending_words.pop_front(), out_word);
            end
        end
    end

    initial begin
        #(12 * 1000000);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        stim_row_t          row;
        t_in_word           w;
        int                 burst_left;
        int unsigned        pick;
        int unsigned        win_eff;
        int                 spin;
        logic [ANGLE_W-1:0] gen_angle;

        burst_left = 0;

        // First sample seeds; wrap across zero; half turn up and down; deadzone
        add_sample(8'h38, 8'hFF, 8'hFF, 32'd0, 1'b1,
                   t_out_word'{12'd4095, 21'd1474200, 24'sd0, 1'b1, 1'b1, 1'b1});
        add_sample(8'hC7, 8'hF0, 8'h00, 32'd32, 1'b1,
                   t_out_word'{12'd0, 21'd0, 24'sd0, 1'b0, 1'b0, 1'b0});
        add_sample(8'h20, 8'h08, 8'h00, 32'd240, 1'b1,
                   t_out_word'{12'd2048, 21'd737280, 24'sd0, 1'b1, 1'b0, 1'b0});
        add_sample(8'h10, 8'h00, 8'h00, 32'd256, 1'b1,
                   t_out_word'{12'd0, 21'd0, 24'sd0, 1'b0, 1'b1, 1'b0});
        add_sample(8'h08, 8'h00, 8'h01, 32'd199472, 1'b1,
                   t_out_word'{12'd1, 21'd360, 24'sd0, 1'b0, 1'b0, 1'b1});
        add_sample(8'h00, 8'h07, 8'hFF, 32'd100000, 1'b0, '0);
        // Shortest window, no deadzone: saturate both ways, hold on zero elapsed
        add_cfg(CFG_WINDOW_US, 24'd1);
        add_cfg(CFG_DEADZONE, 24'd0);
        add_sample(8'h3F, 8'h0F, 8'hFF, 32'd1, 1'b0, '0);
        add_sample(8'h00, 8'h07, 8'hFF, 32'd1, 1'b1,
                   t_out_word'{12'd2047, 21'd736920, 24'sh800000, 1'b0, 1'b0, 1'b0});
        add_sample(8'h00, 8'h07, 8'hFF, 32'd0, 1'b1,
                   t_out_word'{12'd2047, 21'd736920, 24'sh800000, 1'b0, 1'b0, 1'b0});
        add_sample(8'hFF, 8'h0F, 8'hFF, 32'd1, 1'b1,
                   t_out_word'{12'd4095, 21'd1474200, 24'sh7FFFFF, 1'b1, 1'b1, 1'b1});
        // Zero window behaves as one
        add_cfg(CFG_WINDOW_US, 24'd0);
        add_sample(8'hFF, 8'h0F, 8'hFF, 32'd0, 1'b1,
                   t_out_word'{12'd4095, 21'd1474200, 24'sh7FFFFF, 1'b1, 1'b1, 1'b1});
        add_sample(8'h00, 8'h00, 8'h01, 32'd3, 1'b0, '0);
        // Largest window and deadzone; elapsed that wraps all the way round
        add_cfg(CFG_DEADZONE, 24'h00FFFF);
        add_cfg(CFG_WINDOW_US, 24'hFFFFFF);
        add_sample(8'h28, 8'hA0, 8'h02, 32'h00FF_FFFF, 1'b1,
                   t_out_word'{12'd2, 21'd720, 24'sd0, 1'b1, 1'b0, 1'b1});
        add_sample(8'h18, 8'h50, 8'h03, 32'hFFFF_FFFF, 1'b0, '0);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.kind == ROW_CFG) begin
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                drive_stamp = drive_stamp + row.sample.time_us;
                w           = row.sample;
                w.time_us   = drive_stamp;
                send_sample(w, row.typed, row.want);
            end
        end

        gen_angle = last_raw;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_WINDOW_US, WINDOW_RESET);
                    write_reg(CFG_DEADZONE, {8'd0, DEADZONE_RESET});
                end
                1: begin
                    write_reg(CFG_WINDOW_US, 24'd1);
                    write_reg(CFG_DEADZONE, 24'd0);
                end
                2: begin
                    write_reg(CFG_WINDOW_US, 24'hFFFFFF);
                    write_reg(CFG_DEADZONE, 24'h00FFFF);
                end
                3: begin
                    write_reg(CFG_WINDOW_US, 24'd0);
                    write_reg(CFG_DEADZONE, 24'($urandom_range(0, 65535)));
                end
                4: begin
                    write_reg(CFG_WINDOW_US, 24'($urandom_range(1, 5000)));
                    write_reg(CFG_DEADZONE, 24'($urandom_range(0, 2000)));
                end
                default: begin
                    write_reg(CFG_WINDOW_US, 24'($urandom_range(5000, 1000000)));
                    write_reg(CFG_DEADZONE, 24'($urandom_range(0, 300)));
                end
            endcase
            for (int n = 0; n < 150; n++) begin
                if (burst_left == 0) begin
                    idle_sender($urandom_range(1, 10));
                    burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
                end
                burst_left--;
                if ($urandom_range(0, 199) == 0) wait_drained();

                pick    = $urandom_range(0, 15);
                win_eff = (window_reg == '0) ? 1 : window_reg;
                if (pick == 0) begin
                    // jump anywhere in angle and time
                    gen_angle   = ANGLE_W'($urandom);
                    drive_stamp = $urandom;
                end else begin
                    if (pick < 7) spin = $urandom_range(0, 40);
                    else if (pick < 14) spin = $urandom_range(0, 2048);
                    else spin = 2048;
                    if ($urandom_range(0, 1) == 1) spin = -spin;
                    gen_angle = gen_angle + ANGLE_W'(spin);
                    if ($urandom_range(0, 3) == 0) begin
                        drive_stamp = drive_stamp + $urandom_range(0, 3);
                    end else begin
                        drive_stamp = drive_stamp + $urandom_range(0, 2 * win_eff);
                    end
                end
                w.status_byte = 8'($urandom);
                w.angle_high  = {4'($urandom), gen_angle[11:8]};
                w.angle_low   = gen_angle[7:0];
                w.time_us     = drive_stamp;
                send_sample(w, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/eaus_pkg.sv
design/eaus_divider.sv
design/encoder_angle_unwrap_speed_core.sv
design/eaus_checker.sv
sim/testbench.sv
